// ===== hdl/bsw_pkg.sv =====
// Shared types for the bounded segment way counter.
// No dependencies; imported by the interfaces, the ring store and the core.
`default_nettype none

package bsw_pkg;

  localparam int WORD_W   = 32;
  localparam int HEIGHT_W = 16;

  typedef logic [WORD_W-1:0]   word_t;
  typedef logic [HEIGHT_W-1:0] height_t;

  // One window entry: prefix sum at that step and its way count
  typedef struct packed {
    word_t prefix;
    word_t ways;
  } ring_entry_t;

  localparam word_t WORD_ZERO = '0;
  localparam word_t WORD_ONE  = word_t'(1);
  localparam word_t WORD_MAX  = '1;

endpackage

`default_nettype wire

// ===== hdl/bsw_if.sv =====
// Valid/ready channel interfaces for step words in and way-count words out.
// Depends on bsw_pkg for the payload types.
`default_nettype none

interface bsw_in_if;
  import bsw_pkg::*;

  logic    valid;
  logic    ready;
  height_t height;
  logic    first;
  logic    last;

  modport source (output valid, output height, output first, output last, input ready);
  modport sink   (input valid, input height, input first, input last, output ready);
endinterface

interface bsw_out_if;
  import bsw_pkg::*;

  logic  valid;
  logic  ready;
  word_t ways;
  logic  truncated;
  logic  final_res;

  modport source (output valid, output ways, output truncated, output final_res,
                  input ready);
  modport sink   (input valid, input ways, input truncated, input final_res,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/bounded_segment_way_counter_core.sv =====
// Bounded segment way counter: per step, the count of ways to split the
// sequence into jumps whose height sum stays within max_drop.
// Each accepted word is followed by a scan that drops, one ring read per cycle,
// every window entry beyond the limit; the result word is then registered.
// No new word is taken until that scan ends and the result can move on.
// Reset (sync, rst_n low): window seeded on the first accepted word; no clear.
`default_nettype none

module bounded_segment_way_counter_core #(
  parameter int WINDOW_DEPTH = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  bsw_in_if.sink           in_ch,
  bsw_out_if.source        out_ch,
  input  logic             cfg_we,
  input  bsw_pkg::word_t   cfg_wdata
);
  import bsw_pkg::*;

  localparam int SLOT_W = $clog2(WINDOW_DEPTH);
  localparam int PTR_W  = SLOT_W + 1;
  localparam logic [PTR_W-1:0] DEPTH_P   = PTR_W'(WINDOW_DEPTH);
  localparam logic [PTR_W:0]   DEPTH2_P  = (PTR_W+1)'(2 * WINDOW_DEPTH);

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [SLOT_W-1:0] slot_t;

  typedef enum logic {ST_IDLE, ST_SCAN} state_t;

  // Pointer helpers: pointers count modulo twice the depth
  function automatic ptr_t ptr_next(input ptr_t x);
    logic [PTR_W:0] y;
    y = {1'b0, x} + (PTR_W+1)'(1);
    return (y >= DEPTH2_P) ? '0 : y[PTR_W-1:0];
  endfunction

  function automatic slot_t ptr_slot(input ptr_t x);
    ptr_t s;
    s = (x >= DEPTH_P) ? x - DEPTH_P : x;
    return s[SLOT_W-1:0];
  endfunction

  function automatic ptr_t win_count(input ptr_t hd, input ptr_t tl);
    logic [PTR_W:0] c;
    c = (hd >= tl) ? {1'b0, hd} - {1'b0, tl} : {1'b0, hd} + DEPTH2_P - {1'b0, tl};
    return c[PTR_W-1:0];
  endfunction

  state_t state_r, state_nxt;
  ptr_t   head_r, head_nxt;
  ptr_t   tail_r, tail_nxt;
  word_t  total_r, total_nxt;
  word_t  running_r, running_nxt;
  word_t  max_drop_r;
  logic   seed_pend_r, seed_pend_nxt;
  logic   fwd_r, fwd_nxt;
  logic   last_r, last_nxt;
  logic   out_valid_r, out_valid_nxt;
  word_t  out_ways_r, out_ways_nxt;
  logic   out_trunc_r, out_trunc_nxt;
  logic   out_final_r, out_final_nxt;

  logic        wr_en, rd_en;
  slot_t       wr_addr, rd_addr;
  ring_entry_t wr_data, rd_data;

  logic        in_ready, in_take;
  logic        first_eff;
  word_t       base;
  logic [WORD_W:0] sum_ext;
  ptr_t        tail_eff, count;
  word_t       tail_prefix, tail_ways, diff;

  bsw_ring #(.DEPTH(WINDOW_DEPTH)) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_ready     = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_take      = in_ready && in_ch.valid;
  assign in_ch.ready  = in_ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.ways      = out_ways_r;
  assign out_ch.truncated = out_trunc_r;
  assign out_ch.final_res = out_final_r;

  // Accept side: seed on first, add the height with saturation
  assign first_eff = in_ch.first || seed_pend_r;
  assign base      = first_eff ? WORD_ZERO : running_r;
  assign sum_ext   = {1'b0, base} + {{(WORD_W+1-HEIGHT_W){1'b0}}, in_ch.height};
  assign tail_eff  = first_eff ? '0 : tail_r;

  // Scan side: tail entry, seeded entry forwarded past the same-cycle write
  assign count       = win_count(head_r, tail_r);
  assign tail_prefix = fwd_r ? WORD_ZERO : rd_data.prefix;
  assign tail_ways   = fwd_r ? WORD_ONE  : rd_data.ways;
  assign diff        = (running_r >= tail_prefix) ? running_r - tail_prefix : WORD_ZERO;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    total_nxt     = total_r;
    running_nxt   = running_r;
    seed_pend_nxt = seed_pend_r;
    fwd_nxt       = fwd_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_ways_nxt  = out_ways_r;
    out_trunc_nxt = out_trunc_r;
    out_final_nxt = out_final_r;
    wr_en         = 1'b0;
    wr_addr       = ptr_slot(head_r);
    wr_data       = '{prefix: running_r, ways: total_r};
    rd_en         = 1'b0;
    rd_addr       = ptr_slot(tail_eff);

    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          running_nxt   = sum_ext[WORD_W] ? WORD_MAX : sum_ext[WORD_W-1:0];
          last_nxt      = in_ch.last;
          seed_pend_nxt = 1'b0;
          fwd_nxt       = first_eff;
          tail_nxt      = tail_eff;
          rd_en         = 1'b1;
          state_nxt     = ST_SCAN;
          if (first_eff) begin
            // Restart the window with the single seed entry
            head_nxt  = ptr_t'(1);
            total_nxt = WORD_ONE;
            wr_en     = 1'b1;
            wr_addr   = '0;
            wr_data   = '{prefix: WORD_ZERO, ways: WORD_ONE};
          end
        end
      end
      ST_SCAN: begin
        if ((count != '0) && (diff > max_drop_r)) begin
          // Drop the oldest entry and fetch the next one
          total_nxt = total_r - tail_ways;
          tail_nxt  = ptr_next(tail_r);
          rd_en     = 1'b1;
          rd_addr   = ptr_slot(ptr_next(tail_r));
          fwd_nxt   = 1'b0;
        end else begin
          // Store the new entry, evicting the oldest when the ring is full
          wr_en         = 1'b1;
          head_nxt      = ptr_next(head_r);
          out_valid_nxt = 1'b1;
          out_ways_nxt  = total_r;
          out_final_nxt = last_r;
          out_trunc_nxt = (count >= DEPTH_P);
          if (count >= DEPTH_P) begin
            tail_nxt  = ptr_next(tail_r);
            total_nxt = total_r + total_r - tail_ways;
          end else begin
            total_nxt = total_r + total_r;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state and the output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= ptr_t'(1);
      tail_r      <= '0;
      total_r     <= WORD_ONE;
      running_r   <= WORD_ZERO;
      seed_pend_r <= 1'b1;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      total_r     <= total_nxt;
      running_r   <= running_nxt;
      seed_pend_r <= seed_pend_nxt;
      fwd_r       <= fwd_nxt;
      out_valid_r <= out_valid_nxt;
    end
    last_r      <= last_nxt;
    out_ways_r  <= out_ways_nxt;
    out_trunc_r <= out_trunc_nxt;
    out_final_r <= out_final_nxt;
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_drop_r <= WORD_ZERO;
    end else if (cfg_we) begin
      max_drop_r <= cfg_wdata;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bsw_ring.sv =====
// Ring store of window entries: one write port, one registered read port.
// Depends on bsw_pkg for the entry type.
`default_nettype none

module bsw_ring #(
  parameter int DEPTH = 256
) (
  input  logic                            clk,
  input  logic                            wr_en,
  input  logic [$clog2(DEPTH)-1:0]        wr_addr,
  input  bsw_pkg::ring_entry_t            wr_data,
  input  logic                            rd_en,
  input  logic [$clog2(DEPTH)-1:0]        rd_addr,
  output bsw_pkg::ring_entry_t            rd_data
);
  import bsw_pkg::*;

  ring_entry_t mem [DEPTH];

  // Write the entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; hold the data otherwise
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bsw_checker.sv =====
// Port-level checks for the way counter core, bound to the core module.
// Depends on bsw_pkg and on the port names of bounded_segment_way_counter_core.
`default_nettype none

module bsw_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input bsw_pkg::word_t out_ways,
  input logic           out_truncated,
  input logic           out_final_res
);
  import bsw_pkg::*;

  // A stalled result word holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ways)
      && $stable(out_truncated) && $stable(out_final_res))
    else $error("stalled result word changed");

  // No new word while a result waits untaken
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while result blocked");

  // No new word is accepted right after an accept
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after accept");

  // The result register is free the cycle after an accept
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid)
    else $error("result visible one cycle after accept");

endmodule

bind bounded_segment_way_counter_core bsw_checker u_bsw_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_ways      (out_ch.ways),
  .out_truncated (out_ch.truncated),
  .out_final_res (out_ch.final_res)
);

`default_nettype wire

// ===== tb/tb_bounded_segment_way_counter_core.sv =====
// Testbench for bounded_segment_way_counter_core: drives step words, checks way-count words.
// Depends on bsw_pkg and the bsw_in_if / bsw_out_if channel interfaces.
`timescale 1ns / 1ps

module tb_bounded_segment_way_counter_core;
  import bsw_pkg::*;

  localparam int DEPTH        = 256;
  localparam int SLOT_W       = $clog2(DEPTH);
  localparam int QUIET_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 400;
  localparam int MAX_REPORTS  = 200;
  localparam int FULL_RUN     = 270;
  localparam int RANDOM_ITEMS = 550;

  typedef logic [SLOT_W:0] ptr_t;

  typedef struct packed {
    word_t ways;
    logic  truncated;
    logic  final_res;
  } way_result_t;

  // One directed step: limit in force, input word, and optionally the way count
  typedef struct packed {
    word_t   limit;
    height_t height;
    logic    first;
    logic    last;
    logic    known;
    word_t   ways;
  } step_row_t;

  localparam int SCRIPT_LEN = 21;
  localparam step_row_t SCRIPT [SCRIPT_LEN] = '{
    // zero limit, starting from the reset window without a first flag
    '{WORD_ZERO, 16'h0000, 1'b0, 1'b0, 1'b1, 32'd1},
    '{WORD_ZERO, 16'h0000, 1'b0, 1'b1, 1'b1, 32'd2},
    '{WORD_ZERO, 16'h0001, 1'b0, 1'b0, 1'b1, 32'd0},
    '{WORD_ZERO, 16'h0000, 1'b1, 1'b1, 1'b1, 32'd1},
    '{WORD_ZERO, 16'hFFFF, 1'b1, 1'b1, 1'b1, 32'd0},
    // unbounded limit: ways double each step, sequence runs on past last
    '{WORD_MAX,  16'hFFFF, 1'b1, 1'b0, 1'b1, 32'd1},
    '{WORD_MAX,  16'hFFFF, 1'b0, 1'b0, 1'b1, 32'd2},
    '{WORD_MAX,  16'h0000, 1'b0, 1'b0, 1'b1, 32'd4},
    '{WORD_MAX,  16'hAAAA, 1'b0, 1'b1, 1'b1, 32'd8},
    '{WORD_MAX,  16'h5555, 1'b0, 1'b0, 1'b1, 32'd16},
    // small limit: window slides, then a tall step empties it
    '{32'd3,     16'h0001, 1'b1, 1'b0, 1'b1, 32'd1},
    '{32'd3,     16'h0001, 1'b0, 1'b0, 1'b0, 32'd0},
    '{32'd3,     16'h0001, 1'b0, 1'b0, 1'b0, 32'd0},
    '{32'd3,     16'h0001, 1'b0, 1'b0, 1'b0, 32'd0},
    '{32'd3,     16'h0002, 1'b0, 1'b1, 1'b0, 32'd0},
    '{32'd3,     16'h0004, 1'b0, 1'b0, 1'b0, 32'd0},
    // limit equal to the tallest step, then a wide limit
    '{32'd65535, 16'hFFFF, 1'b1, 1'b0, 1'b1, 32'd1},
    '{32'd65535, 16'h0001, 1'b0, 1'b0, 1'b0, 32'd0},
    '{32'd65535, 16'h8000, 1'b0, 1'b1, 1'b0, 32'd0},
    '{32'h8000_0000, 16'h7FFF, 1'b1, 1'b0, 1'b1, 32'd1},
    '{32'h8000_0000, 16'hFFFF, 1'b0, 1'b1, 1'b1, 32'd2}
  };

  logic  clk;
  logic  rst_n;
  logic  cfg_we;
  word_t cfg_wdata;

  bsw_in_if  step_if();
  bsw_out_if way_if();

  bounded_segment_way_counter_core #(
    .WINDOW_DEPTH(DEPTH)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (step_if),
    .out_ch   (way_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  way_result_t pending_ways [$];
  int          fault_count  = 0;
  int          quiet_cycles = 0;
  logic        idle_on      = 1'b1;
  logic        hold_request = 1'b0;

  // Window model: prefix sums and way counts of the steps still reachable
  word_t prefix_mem [DEPTH];
  word_t ways_mem [DEPTH];
  word_t level_sum;
  word_t window_sum;
  word_t drop_limit;
  ptr_t  head_ptr;
  ptr_t  tail_ptr;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void seed_window();
    prefix_mem[0] = WORD_ZERO;
    ways_mem[0]   = WORD_ONE;
    tail_ptr      = '0;
    head_ptr      = ptr_t'(1);
    window_sum    = WORD_ONE;
    level_sum     = WORD_ZERO;
  endfunction

  function automatic ptr_t held();
    return ptr_t'(head_ptr - tail_ptr);
  endfunction

  function automatic void retire_oldest();
    window_sum = window_sum - ways_mem[tail_ptr[SLOT_W-1:0]];
    tail_ptr   = tail_ptr + 1'b1;
  endfunction

  function automatic way_result_t predict_ways(height_t h, logic f, logic l);
    logic [WORD_W:0] wide;
    word_t           oldest;
    word_t           span;
    way_result_t     res;
    if (f) seed_window();
    // saturate the running height sum
    wide      = {1'b0, level_sum} + {{(WORD_W + 1 - HEIGHT_W){1'b0}}, h};
    level_sum = wide[WORD_W] ? WORD_MAX : wide[WORD_W-1:0];
    // drop entries whose jump to this step would exceed the limit
    while (held() != 0) begin
      oldest = prefix_mem[tail_ptr[SLOT_W-1:0]];
      span   = (level_sum >= oldest) ? level_sum - oldest : WORD_ZERO;
      if (span <= drop_limit) break;
      retire_oldest();
    end
    res.ways      = window_sum;
    res.truncated = 1'b0;
    res.final_res = l;
    // make room when the store is full
    if (held() >= DEPTH) begin
      retire_oldest();
      res.truncated = 1'b1;
    end
    prefix_mem[head_ptr[SLOT_W-1:0]] = level_sum;
    ways_mem[head_ptr[SLOT_W-1:0]]   = res.ways;
    head_ptr   = head_ptr + 1'b1;
    window_sum = window_sum + res.ways;
    return res;
  endfunction

  function automatic int idle_draw();
    return idle_on ? $urandom_range(0, 5) : 0;
  endfunction

  function automatic word_t pick_limit();
    case ($urandom_range(0, 5))
      0:       return WORD_ZERO;
      1:       return WORD_MAX;
      2:       return word_t'($urandom_range(0, 64));
      3:       return word_t'($urandom_range(1000, 300000));
      4:       return word_t'($urandom);
      default: return word_t'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic height_t pick_height(int style);
    case (style)
      0:       return height_t'($urandom_range(0, 15));
      1:       return height_t'($urandom_range(0, 600));
      2:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return height_t'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic report_field(input string field, input word_t want, input word_t got);
    fault_count++;
    if (fault_count <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
  endtask

  // Compare one accepted result word against the oldest expectation
  task automatic check_way(input way_result_t got);
    way_result_t want;
    if (pending_ways.size() == 0) begin
      report_field("unexpected word, ways", WORD_ZERO, got.ways);
    end else begin
      want = pending_ways.pop_front();
      if (got.ways !== want.ways)
        report_field("ways", want.ways, got.ways);
      if (got.truncated !== want.truncated)
        report_field("truncated", word_t'(want.truncated), word_t'(got.truncated));
      if (got.final_res !== want.final_res)
        report_field("final_res", word_t'(want.final_res), word_t'(got.final_res));
    end
  endtask

  // Offer one step word, hold it until accepted, then record its way count
  task automatic send_step(input height_t h, input logic f, input logic l,
                           input logic known, input word_t known_ways);
    int          gap;
    logic        took;
    way_result_t res;
    gap = idle_draw();
    if (gap > 0) begin
      step_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    step_if.valid  <= 1'b1;
    step_if.height <= h;
    step_if.first  <= f;
    step_if.last   <= l;
    // sample ready mid-cycle, where it holds its value for the coming edge
    do begin
      @(negedge clk);
      took = step_if.ready;
      @(posedge clk);
    end while (!took);
    res = predict_ways(h, f, l);
    if (known) res = '{ways: known_ways, truncated: 1'b0, final_res: l};
    pending_ways.push_back(res);
  endtask

  // Drain all outstanding words, then write the limit register
  task automatic set_limit(input word_t value);
    step_if.valid <= 1'b0;
    while (pending_ways.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we     <= 1'b0;
    drop_limit  = value;
  endtask

  // Short sequences with random limits and content, plus stray flags
  task automatic run_mixed(input int budget);
    int   sent;
    int   seq_len;
    int   style;
    logic f;
    logic l;
    sent = 0;
    while (sent < budget) begin
      set_limit(pick_limit());
      idle_on = ($urandom_range(0, 3) != 0);
      style   = $urandom_range(0, 3);
      repeat ($urandom_range(1, 4)) begin
        seq_len = $urandom_range(1, 24);
        for (int k = 0; k < seq_len; k++) begin
          f = (k == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 29) == 0);
          l = (k == seq_len - 1) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 29) == 0);
          send_step(pick_height(style), f, l, 1'b0, WORD_ZERO);
          sent++;
        end
      end
    end
  endtask

  // One long sequence under a wide limit so the store overflows
  task automatic run_full_window();
    set_limit(WORD_MAX - word_t'($urandom_range(0, 1000)));
    idle_on = 1'b1;
    for (int k = 0; k < FULL_RUN; k++) begin
      if (k == FULL_RUN / 2) hold_request = 1'b1;
      send_step(height_t'($urandom_range(0, 255)), k == 0, k == FULL_RUN - 1,
                1'b0, WORD_ZERO);
    end
  endtask

  initial begin : stimulus
    rst_n          <= 1'b0;
    step_if.valid  <= 1'b0;
    step_if.height <= '0;
    step_if.first  <= 1'b0;
    step_if.last   <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_wdata      <= WORD_ZERO;
    seed_window();
    drop_limit = WORD_ZERO;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed steps
    for (int i = 0; i < SCRIPT_LEN; i++) begin
      if (i == 0 || SCRIPT[i].limit != drop_limit) set_limit(SCRIPT[i].limit);
      send_step(SCRIPT[i].height, SCRIPT[i].first, SCRIPT[i].last,
                SCRIPT[i].known, SCRIPT[i].ways);
    end

    run_mixed((RANDOM_ITEMS - FULL_RUN) / 2);
    run_full_window();
    run_mixed((RANDOM_ITEMS - FULL_RUN) / 2);

    // wait out the tail, then wait on for stray words
    step_if.valid <= 1'b0;
    while (pending_ways.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fault_count == 0) begin
      $display("bounded_segment_way_counter_core verification clean");
    end else begin
      $display("bounded_segment_way_counter_core verification failed");
    end
    $finish;
  end

  // Result side: random stalls, plus one long hold when asked
  initial begin : result_sink
    int          gap;
    logic        took;
    way_result_t got;
    way_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        gap          = HOLD_CYCLES;
        hold_request = 1'b0;
      end else begin
        gap = idle_draw();
      end
      if (gap > 0) begin
        way_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      way_if.ready <= 1'b1;
      // capture the word mid-cycle, where it holds its value for the coming edge
      do begin
        @(negedge clk);
        took = way_if.valid;
        got  = '{ways: way_if.ways, truncated: way_if.truncated,
                 final_res: way_if.final_res};
        @(posedge clk);
      end while (!took);
      check_way(got);
    end
  end

  // Watchdog: end the run if no word moves on either side for too long
  always @(negedge clk) begin
    if (!rst_n || (step_if.valid && step_if.ready) || (way_if.valid && way_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("bounded_segment_way_counter_core verification failed");
        $finish;
      end
    end
  end

endmodule
